>>> hw/rtl/nwp_pkg.sv
// Shared constants, codes and types for the NC word parser and motion command core.
`timescale 1ns / 1ps

package nwp_pkg;

    localparam int POS_WIDTH_DEF   = 24;
    localparam int CH_WIDTH        = 8;
    localparam int SPEED_WIDTH     = 16;
    localparam int KIND_WIDTH      = 2;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int UM_PER_MM       = 1000;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_OPEN  = 2'd1;
    localparam logic [1:0] MODE_SIGN  = 2'd2;
    localparam logic [1:0] MODE_DIGIT = 2'd3;

    localparam logic [1:0] LET_NONE = 2'd0;
    localparam logic [1:0] LET_X    = 2'd1;
    localparam logic [1:0] LET_Y    = 2'd2;
    localparam logic [1:0] LET_Z    = 2'd3;

    localparam logic [KIND_WIDTH-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_AXIS = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_LINE = 2'd2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DRILL  = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TRAVEL = 1'b1;

    localparam logic [SPEED_WIDTH-1:0] DRILL_RESET  = 16'd60;
    localparam logic [SPEED_WIDTH-1:0] TRAVEL_RESET = 16'd120;

    localparam logic [CH_WIDTH-1:0] CH_X     = 8'h58;
    localparam logic [CH_WIDTH-1:0] CH_Y     = 8'h59;
    localparam logic [CH_WIDTH-1:0] CH_Z     = 8'h5A;
    localparam logic [CH_WIDTH-1:0] CH_N     = 8'h4E;
    localparam logic [CH_WIDTH-1:0] CH_POINT = 8'h2E;
    localparam logic [CH_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_WIDTH-1:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic       done;
        logic [1:0] letter;
    } word_evt_t;

    function automatic logic [6:0] frac_scale(input logic [1:0] idx);
        logic [6:0] s;
        unique case (idx)
            2'd0:    s = 7'd100;
            2'd1:    s = 7'd10;
            2'd2:    s = 7'd1;
            default: s = 7'd0;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] letter_of(input logic [CH_WIDTH-1:0] c);
        logic [1:0] l;
        priority if (c == CH_X) l = LET_X;
        else if (c == CH_Y)     l = LET_Y;
        else if (c == CH_Z)     l = LET_Z;
        else                    l = LET_NONE;
        return l;
    endfunction

endpackage

>>> hw/rtl/nwp_parse.sv
// Word and number parser: tracks address letters and builds the micrometre value.
`timescale 1ns / 1ps

module nwp_parse
    import nwp_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [CH_WIDTH-1:0]         ch,
    output word_evt_t                   evt,
    output logic signed [POS_WIDTH-1:0] value
);

    localparam int SUM_W = POS_WIDTH + 4;
    localparam logic [SUM_W-1:0] CAP_WIDE = SUM_W'(1) << (POS_WIDTH - 1);

    logic [1:0]           mode_reg, mode_next;
    logic [1:0]           letter_reg, letter_next;
    logic [POS_WIDTH-1:0] mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [1:0]           frac_reg, frac_next;
    logic                 point_reg, point_next;
    logic                 ended_reg, ended_next;

    logic                 is_digit;
    logic [3:0]           digit;
    logic [1:0]           ch_letter;
    logic [SUM_W-1:0]     mag_wide;
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     sat;

    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit     = ch[3:0];
    assign ch_letter = letter_of(ch);
    assign mag_wide  = {4'b0, mag_reg};

    always_comb
    begin
        if (!point_reg)
        begin
            sum = (mag_wide << 3) + (mag_wide << 1)
                + SUM_W'(digit) * SUM_W'(UM_PER_MM);
        end
        else if (frac_reg != 2'd3)
        begin
            sum = mag_wide + SUM_W'(digit) * SUM_W'(frac_scale(frac_reg));
        end
        else
        begin
            sum = mag_wide;
        end
        sat = (sum > CAP_WIDE) ? CAP_WIDE : sum;
    end

    always_comb
    begin
        if (neg_reg && (mag_reg != '0))
            value = ~mag_reg + POS_WIDTH'(1);
        else if (mag_reg[POS_WIDTH-1])
            value = {1'b0, {(POS_WIDTH - 1){1'b1}}};
        else
            value = mag_reg;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        letter_next = letter_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        frac_next   = frac_reg;
        point_next  = point_reg;
        ended_next  = ended_reg;
        evt.done    = 1'b0;
        evt.letter  = letter_reg;

        if (step)
        begin
            if (mode_reg == MODE_IDLE)
            begin
                if ((ch_letter != LET_NONE) || (ch == CH_N))
                begin
                    mode_next   = MODE_OPEN;
                    letter_next = ch_letter;
                    mag_next    = '0;
                    neg_next    = 1'b0;
                    frac_next   = 2'd0;
                    point_next  = 1'b0;
                    ended_next  = 1'b0;
                end
            end
            else if (is_digit)
            begin
                if (!ended_reg)
                begin
                    mag_next  = sat[POS_WIDTH-1:0];
                    mode_next = MODE_DIGIT;
                    if (point_reg && (frac_reg != 2'd3))
                        frac_next = frac_reg + 2'd1;
                end
            end
            else if (ch == CH_MINUS)
            begin
                if (!ended_reg)
                begin
                    if (mode_reg == MODE_OPEN)
                    begin
                        neg_next  = 1'b1;
                        mode_next = MODE_SIGN;
                    end
                    else
                    begin
                        ended_next = 1'b1;
                    end
                end
            end
            else if (ch == CH_POINT)
            begin
                if (!ended_reg)
                begin
                    if (point_reg)
                        ended_next = 1'b1;
                    else
                        point_next = 1'b1;
                    mode_next = MODE_DIGIT;
                end
            end
            else
            begin
                evt.done    = 1'b1;
                mode_next   = (ch_letter != LET_NONE) ? MODE_OPEN : MODE_IDLE;
                letter_next = ch_letter;
                mag_next    = '0;
                neg_next    = 1'b0;
                frac_next   = 2'd0;
                point_next  = 1'b0;
                ended_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            letter_reg <= LET_NONE;
            mag_reg    <= '0;
            neg_reg    <= 1'b0;
            frac_reg   <= 2'd0;
            point_reg  <= 1'b0;
            ended_reg  <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            letter_reg <= letter_next;
            mag_reg    <= mag_next;
            neg_reg    <= neg_next;
            frac_reg   <= frac_next;
            point_reg  <= point_next;
            ended_reg  <= ended_next;
        end
    end

    a_frac_needs_point: assert property (@(posedge clk) disable iff (!rst_n)
        (frac_reg != 2'd0) |-> point_reg)
        else $error("fraction digits counted without a point");

    a_sign_mode_negative: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_SIGN) |-> neg_reg)
        else $error("sign state without negative flag");

    a_mag_capped: assert property (@(posedge clk) disable iff (!rst_n)
        mag_reg[POS_WIDTH-1] |-> (mag_reg[POS_WIDTH-2:0] == '0))
        else $error("magnitude above saturation cap");

endmodule

>>> hw/rtl/nwp_motion.sv
// Motion stage: feed rate selection, position tracking and the result register.
`timescale 1ns / 1ps

module nwp_motion
    import nwp_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  word_evt_t                   evt,
    input  logic signed [POS_WIDTH-1:0] value,
    input  logic                        cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [SPEED_WIDTH-1:0]      cfg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        speed_change,
    output logic [SPEED_WIDTH-1:0]      speed,
    output logic [KIND_WIDTH-1:0]       move_kind,
    output logic signed [POS_WIDTH-1:0] target_x,
    output logic signed [POS_WIDTH-1:0] target_y,
    output logic signed [POS_WIDTH-1:0] target_z
);

    logic [SPEED_WIDTH-1:0]      drill_reg, travel_reg;
    logic [SPEED_WIDTH-1:0]      active_reg, active_next;
    logic signed [POS_WIDTH-1:0] pend_x_reg, pend_x_next;
    logic signed [POS_WIDTH-1:0] pend_y_reg, pend_y_next;
    logic signed [POS_WIDTH-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_WIDTH-1:0] pos_y_reg, pos_y_next;
    logic signed [POS_WIDTH-1:0] pos_z_reg, pos_z_next;
    logic                        valid_reg, valid_next;
    logic                        change_reg;
    logic [SPEED_WIDTH-1:0]      speed_reg;
    logic [KIND_WIDTH-1:0]       kind_reg;
    logic signed [POS_WIDTH-1:0] tx_reg, ty_reg, tz_reg;

    logic                        emit;
    logic                        changed;
    logic [KIND_WIDTH-1:0]       kind;
    logic signed [POS_WIDTH-1:0] tz;

    always_comb
    begin
        active_next = active_reg;
        changed     = 1'b0;
        if (!value[POS_WIDTH-1] && (active_reg != travel_reg))
        begin
            active_next = travel_reg;
            changed     = 1'b1;
        end
        else if (value[POS_WIDTH-1] && (active_reg == travel_reg))
        begin
            active_next = drill_reg;
            changed     = 1'b1;
        end
    end

    always_comb
    begin
        pend_x_next = pend_x_reg;
        pend_y_next = pend_y_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        pos_z_next  = pos_z_reg;
        emit        = 1'b0;
        kind        = KIND_AXIS;
        tz          = pos_z_reg;
        if (evt.done)
        begin
            unique case (evt.letter)
                LET_X:
                begin
                    pend_x_next = value;
                end
                LET_Y:
                begin
                    emit        = 1'b1;
                    pend_y_next = value;
                    pos_x_next  = pend_x_reg;
                    pos_y_next  = value;
                    if ((pos_z_reg > 0) || (pend_x_reg == pos_x_reg) || (value == pos_y_reg))
                        kind = KIND_AXIS;
                    else
                        kind = KIND_LINE;
                end
                LET_Z:
                begin
                    emit       = 1'b1;
                    tz         = value;
                    pos_x_next = pend_x_reg;
                    pos_y_next = pend_y_reg;
                    pos_z_next = value;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drill_reg  <= DRILL_RESET;
            travel_reg <= TRAVEL_RESET;
            active_reg <= DRILL_RESET;
            pend_x_reg <= '0;
            pend_y_reg <= '0;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == CFG_DRILL))
                drill_reg <= cfg_data;
            if (cfg_write && (cfg_index == CFG_TRAVEL))
                travel_reg <= cfg_data;
            if (emit)
                active_reg <= active_next;
            pend_x_reg <= pend_x_next;
            pend_y_reg <= pend_y_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            pos_z_reg  <= pos_z_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            change_reg <= changed;
            speed_reg  <= active_next;
            kind_reg   <= kind;
            tx_reg     <= pend_x_reg;
            ty_reg     <= (evt.letter == LET_Y) ? value : pend_y_reg;
            tz_reg     <= tz;
        end
    end

    assign out_valid    = valid_reg;
    assign speed_change = change_reg;
    assign speed        = speed_reg;
    assign move_kind    = kind_reg;
    assign target_x     = tx_reg;
    assign target_y     = ty_reg;
    assign target_z     = tz_reg;

    a_kind_is_move: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((kind_reg == KIND_AXIS) || (kind_reg == KIND_LINE)))
        else $error("result without a move kind");

    a_speed_tracks_active: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (speed_reg == active_reg))
        else $error("reported speed differs from active rate");

    a_pos_is_target: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((tx_reg == pos_x_reg) && (ty_reg == pos_y_reg) && (tz_reg == pos_z_reg)))
        else $error("position not advanced to move target");

endmodule

>>> hw/rtl/nc_word_parser_motion_cmd_core.sv
// Top level of the NC word parser and motion command core.
`timescale 1ns / 1ps

// Usage:
//   Program text enters one byte per beat on the in channel (in_valid, in_ready, ch).
//   Each Y or Z word, once closed by a byte that is not a digit, '-' or '.',
//   gives one move beat on the out channel: speed_change, speed, move_kind
//   and target_x/y/z in micrometres. X and N words give no beat.
//   Feed rates are written on the cfg channel: index 0 drill rate, 1 travel rate;
//   cfg_ready is always high. Write them only while no text is in flight.
//   An accepted byte sits in the input register (ch_reg) and is parsed from
//   there once the result register is free or being taken; a closing Y or Z
//   byte then loads the result register, from which its move beat is offered.
//   Throughput: one byte per cycle while results are taken, since the parse
//   and motion update between the input and result registers are combinational.
//   A stalled result holds the result register; the byte behind it waits in
//   the input register and in_ready drops until out_ready returns.
//   Reset clears parser state and positions, sets the rates to 60 and 120
//   mm/min with the drill rate active.

module nc_word_parser_motion_cmd_core
    import nwp_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [CH_WIDTH-1:0]         ch,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        speed_change,
    output logic [SPEED_WIDTH-1:0]      speed,
    output logic [KIND_WIDTH-1:0]       move_kind,
    output logic signed [POS_WIDTH-1:0] target_x,
    output logic signed [POS_WIDTH-1:0] target_y,
    output logic signed [POS_WIDTH-1:0] target_z,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [SPEED_WIDTH-1:0]      cfg_data
);

    logic                        hold_reg, hold_next;
    logic [CH_WIDTH-1:0]         ch_reg;
    logic                        step;
    word_evt_t                   evt;
    logic signed [POS_WIDTH-1:0] value;

    assign step      = hold_reg && (!out_valid || out_ready);
    assign in_ready  = !hold_reg || step;
    assign hold_next = (in_valid && in_ready) ? 1'b1 : (step ? 1'b0 : hold_reg);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= 1'b0;
        else
            hold_reg <= hold_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            ch_reg <= ch;
    end

    nwp_parse #(
        .POS_WIDTH (POS_WIDTH)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .ch    (ch_reg),
        .evt   (evt),
        .value (value)
    );

    nwp_motion #(
        .POS_WIDTH (POS_WIDTH)
    ) u_motion (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt          (evt),
        .value        (value),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .speed_change (speed_change),
        .speed        (speed),
        .move_kind    (move_kind),
        .target_x     (target_x),
        .target_y     (target_y),
        .target_z     (target_z)
    );

endmodule
